[rtl/g3ms_pkg.sv]
// Shared types, constants and the reciprocal table of the 3x3 mean smoother.
// Used by every other file of the block but g3ms_ram; depends on nothing.
package g3ms_pkg;

  // Grid limits
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;

  // Field widths
  localparam int SampleW     = 16;
  localparam int RowW        = 12;
  localparam int ColW        = 10;
  localparam int CfgWidthW   = 11;
  localparam int CfgHeightW  = 13;
  localparam int CfgDataW    = 13;
  localparam int CfgIdxW     = 2;
  localparam int SumW        = 20;   // nine 16-bit samples
  localparam int CntW        = 4;    // neighbour count 1..9
  localparam int RecipShift  = 24;   // >= SumW + ceil(log2(9))
  localparam int RecipW      = RecipShift + 1;
  localparam int ProdW       = SumW + RecipW;
  localparam int LineDepth   = MaxWidth;

  typedef logic [SampleW-1:0]    sample_t;
  typedef logic [RowW-1:0]       row_t;
  typedef logic [ColW-1:0]       col_t;
  typedef logic [CfgWidthW-1:0]  cfg_width_t;
  typedef logic [CfgHeightW-1:0] cfg_height_t;
  typedef logic [CfgDataW-1:0]   cfg_data_t;
  typedef logic [CfgIdxW-1:0]    cfg_idx_t;
  typedef logic [SumW-1:0]       sum_t;
  typedef logic [CntW-1:0]       cnt_t;
  typedef logic [RecipW-1:0]     recip_t;
  typedef logic [ProdW-1:0]      prod_t;

  // Register indexes
  localparam cfg_idx_t CfgIdxWidth  = cfg_idx_t'(0);
  localparam cfg_idx_t CfgIdxHeight = cfg_idx_t'(1);

  localparam cfg_width_t  CfgWidthRst  = cfg_width_t'(257);
  localparam cfg_height_t CfgHeightRst = cfg_height_t'(257);

  // Which result of a sample: the point up-left, up, left, or the sample's own point
  typedef logic [1:0] res_sel_t;
  localparam res_sel_t ResUpLeft = res_sel_t'(0);
  localparam res_sel_t ResUp     = res_sel_t'(1);
  localparam res_sel_t ResLeft   = res_sel_t'(2);
  localparam res_sel_t ResHere   = res_sel_t'(3);

  // Controller to datapath commands
  typedef struct packed {
    logic     capture;   // take the sample, start line store read
    logic     load;      // line store data back, write line stores
    logic     calc;      // form masked sum and count for sel
    res_sel_t sel;
    logic     last;      // this result ends the word's run
    logic     mul;       // reciprocal multiply
    logic     push;      // load the output register
    logic     advance;   // shift window, step position
  } ctrl_cmd_t;

  typedef struct packed {
    logic [3:0] emit_mask;  // results due, indexed by res_sel_t
    logic       out_busy;   // output register holds an untaken word
  } dp_status_t;

  // ceil(2^RecipShift / d): exact truncated quotient for any SumW-bit dividend
  function automatic recip_t recip(input cnt_t d);
    recip_t r;
    unique case (d)
      cnt_t'(1): r = recip_t'(16777216);
      cnt_t'(2): r = recip_t'(8388608);
      cnt_t'(3): r = recip_t'(5592406);
      cnt_t'(4): r = recip_t'(4194304);
      cnt_t'(5): r = recip_t'(3355444);
      cnt_t'(6): r = recip_t'(2796203);
      cnt_t'(7): r = recip_t'(2396746);
      cnt_t'(8): r = recip_t'(2097152);
      cnt_t'(9): r = recip_t'(1864136);
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/g3ms_if.sv]
// Stream and configuration interfaces of the 3x3 mean smoother.
// Depends on g3ms_pkg.
interface g3ms_sample_if;
  logic                 valid;
  logic                 ready;
  g3ms_pkg::sample_t    height_sample;
  modport source (output valid, output height_sample, input ready);
  modport sink   (input valid, input height_sample, output ready);
endinterface

interface g3ms_result_if;
  logic                 valid;
  logic                 ready;
  g3ms_pkg::sample_t    smoothed_height;
  g3ms_pkg::row_t       out_row;
  g3ms_pkg::col_t       out_col;
  logic                 last_of_run;
  logic                 frame_done;
  modport source (output valid, output smoothed_height, output out_row, output out_col,
                  output last_of_run, output frame_done, input ready);
  modport sink   (input valid, input smoothed_height, input out_row, input out_col,
                  input last_of_run, input frame_done, output ready);
endinterface

interface g3ms_cfg_if;
  logic                 valid;
  logic                 ready;
  g3ms_pkg::cfg_idx_t   index;
  g3ms_pkg::cfg_data_t  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/g3ms_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module g3ms_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/g3ms_ctrl.sv]
// Sequencer of the 3x3 mean smoother: one sample at a time, up to four results.
// Depends on g3ms_pkg; drives g3ms_dpath through ctrl_cmd_t.
module g3ms_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  g3ms_pkg::dp_status_t status_i,
  output g3ms_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;
  localparam logic [2:0] StCalc = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StPush = 3'd4;

  logic [2:0] state_q, state_d;
  logic [3:0] mask_q, mask_d;
  logic [3:0] rest;
  g3ms_pkg::res_sel_t sel;

  // lowest pending result goes first (raster order)
  always_comb begin
    priority if (mask_q[g3ms_pkg::ResUpLeft]) sel = g3ms_pkg::ResUpLeft;
    else if (mask_q[g3ms_pkg::ResUp])         sel = g3ms_pkg::ResUp;
    else if (mask_q[g3ms_pkg::ResLeft])       sel = g3ms_pkg::ResLeft;
    else                                      sel = g3ms_pkg::ResHere;
    rest      = mask_q;
    rest[sel] = 1'b0;
  end

  always_comb begin
    state_d    = state_q;
    mask_d     = mask_q;
    cmd_o      = '0;
    cmd_o.sel  = sel;
    in_ready_o = (state_q == StIdle);
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StLoad;
        end
      end
      StLoad: begin
        cmd_o.load = 1'b1;
        mask_d     = status_i.emit_mask;
        if (status_i.emit_mask == '0) begin
          cmd_o.advance = 1'b1;
          state_d       = StIdle;
        end else begin
          state_d = StCalc;
        end
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        cmd_o.last = (rest == '0);
        mask_d     = rest;
        state_d    = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StPush;
      end
      StPush: begin
        if (!status_i.out_busy) begin
          cmd_o.push = 1'b1;
          if (mask_q == '0) begin
            cmd_o.advance = 1'b1;
            state_d       = StIdle;
          end else begin
            state_d = StCalc;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mask_q  <= '0;
    end else begin
      state_q <= state_d;
      mask_q  <= mask_d;
    end
  end

endmodule

[rtl/g3ms_dpath.sv]
// Datapath of the 3x3 mean smoother: config, position, line stores, window,
// masked sum, reciprocal divide and the output register.
// Depends on g3ms_pkg and g3ms_ram.
module g3ms_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  g3ms_pkg::ctrl_cmd_t  cmd_i,
  output g3ms_pkg::dp_status_t status_o,
  input  g3ms_pkg::sample_t    sample_i,
  input  logic                 cfg_valid_i,
  input  g3ms_pkg::cfg_idx_t   cfg_index_i,
  input  g3ms_pkg::cfg_data_t  cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output g3ms_pkg::sample_t    out_height_o,
  output g3ms_pkg::row_t       out_row_o,
  output g3ms_pkg::col_t       out_col_o,
  output logic                 out_last_o,
  output logic                 out_done_o
);

  // Config registers and effective size
  g3ms_pkg::cfg_width_t  cfg_width_q, eff_w;
  g3ms_pkg::cfg_height_t cfg_height_q, eff_h;
  logic cfg_hit;

  assign cfg_hit = cfg_valid_i &&
                   (cfg_index_i == g3ms_pkg::CfgIdxWidth ||
                    cfg_index_i == g3ms_pkg::CfgIdxHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= g3ms_pkg::CfgWidthRst;
      cfg_height_q <= g3ms_pkg::CfgHeightRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == g3ms_pkg::CfgIdxWidth) begin
        cfg_width_q <= cfg_data_i[g3ms_pkg::CfgWidthW-1:0];
      end
      if (cfg_index_i == g3ms_pkg::CfgIdxHeight) begin
        cfg_height_q <= cfg_data_i;
      end
    end
  end

  // zero acts as one, oversize width clamps to the store size, height to MaxHeight
  always_comb begin
    priority if (cfg_width_q == '0) begin
      eff_w = g3ms_pkg::cfg_width_t'(1);
    end else if (cfg_width_q > g3ms_pkg::cfg_width_t'(g3ms_pkg::MaxWidth)) begin
      eff_w = g3ms_pkg::cfg_width_t'(g3ms_pkg::MaxWidth);
    end else begin
      eff_w = cfg_width_q;
    end
    priority if (cfg_height_q == '0) begin
      eff_h = g3ms_pkg::cfg_height_t'(1);
    end else if (cfg_height_q > g3ms_pkg::cfg_height_t'(g3ms_pkg::MaxHeight)) begin
      eff_h = g3ms_pkg::cfg_height_t'(g3ms_pkg::MaxHeight);
    end else begin
      eff_h = cfg_height_q;
    end
  end

  // Position of the next sample
  g3ms_pkg::row_t row_q, row_d, cur_r, r_q;
  g3ms_pkg::col_t col_q, col_d, cur_c, c_q;
  logic row_end, last_row, row_end_q, last_row_q;

  assign cur_c    = (g3ms_pkg::cfg_width_t'(col_q) < eff_w) ? col_q : '0;
  assign cur_r    = (g3ms_pkg::cfg_height_t'(row_q) < eff_h) ? row_q : '0;
  assign row_end  = (g3ms_pkg::cfg_width_t'(cur_c) == eff_w - g3ms_pkg::cfg_width_t'(1));
  assign last_row = (g3ms_pkg::cfg_height_t'(cur_r) == eff_h - g3ms_pkg::cfg_height_t'(1));

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    priority if (cfg_hit) begin
      row_d = '0;
      col_d = '0;
    end else if (cmd_i.advance) begin
      if (row_end_q) begin
        col_d = '0;
        row_d = last_row_q ? '0 : r_q + g3ms_pkg::row_t'(1);
      end else begin
        col_d = c_q + g3ms_pkg::col_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Sample capture
  g3ms_pkg::sample_t sample_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q   <= sample_i;
      r_q        <= cur_r;
      c_q        <= cur_c;
      row_end_q  <= row_end;
      last_row_q <= last_row;
    end
  end

  // Line stores: rows r-1 and r-2, read at capture, written back at load
  g3ms_pkg::sample_t prev_rd, older_rd;

  g3ms_ram #(
    .Width(g3ms_pkg::SampleW),
    .Depth(g3ms_pkg::LineDepth)
  ) u_prev_ram (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.load),
    .wr_addr_i(c_q),
    .wr_data_i(sample_q),
    .rd_en_i  (cmd_i.capture),
    .rd_addr_i(cur_c),
    .rd_data_o(prev_rd)
  );

  g3ms_ram #(
    .Width(g3ms_pkg::SampleW),
    .Depth(g3ms_pkg::LineDepth)
  ) u_older_ram (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.load),
    .wr_addr_i(c_q),
    .wr_data_i(prev_rd),
    .rd_en_i  (cmd_i.capture),
    .rd_addr_i(cur_c),
    .rd_data_o(older_rd)
  );

  // Window: columns c-2, c-1 in registers, column c from the line stores
  g3ms_pkg::sample_t win_q [3][2];
  g3ms_pkg::sample_t col2_q [3];
  g3ms_pkg::sample_t col_new [3];
  g3ms_pkg::sample_t v [3][3];

  // fresh column as it arrives from the line stores
  always_comb begin
    col_new[0] = older_rd;
    col_new[1] = prev_rd;
    col_new[2] = sample_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= '0;
        win_q[k][1] <= '0;
        col2_q[k]   <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        for (int k = 0; k < 3; k++) begin
          col2_q[k] <= col_new[k];
        end
      end
      // a sample with no result shifts its column in during the load cycle
      if (cmd_i.advance) begin
        for (int k = 0; k < 3; k++) begin
          win_q[k][1] <= win_q[k][0];
          win_q[k][0] <= cmd_i.load ? col_new[k] : col2_q[k];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v[k][0] = win_q[k][1];
      v[k][1] = win_q[k][0];
      v[k][2] = col2_q[k];
    end
  end

  // Results due for this sample
  logic r_ge1, c_ge1;
  assign r_ge1 = (r_q != '0);
  assign c_ge1 = (c_q != '0);

  always_comb begin
    status_o.emit_mask = '0;
    status_o.emit_mask[g3ms_pkg::ResUpLeft] = r_ge1 && c_ge1;
    status_o.emit_mask[g3ms_pkg::ResUp]     = r_ge1 && row_end_q;
    status_o.emit_mask[g3ms_pkg::ResLeft]   = last_row_q && c_ge1;
    status_o.emit_mask[g3ms_pkg::ResHere]   = last_row_q && row_end_q;
  end

  // Masked sum and count around the selected centre
  logic [2:0] row_in, col_in;
  logic sel_cur_row, sel_cur_col;
  g3ms_pkg::sum_t sum_d, sum_q;
  g3ms_pkg::cnt_t cnt_d, cnt_q;
  g3ms_pkg::row_t res_row_q;
  g3ms_pkg::col_t res_col_q;
  logic res_last_q, res_done_q;

  assign sel_cur_row = (cmd_i.sel == g3ms_pkg::ResLeft) || (cmd_i.sel == g3ms_pkg::ResHere);
  assign sel_cur_col = (cmd_i.sel == g3ms_pkg::ResUp) || (cmd_i.sel == g3ms_pkg::ResHere);

  always_comb begin
    row_in[0] = (r_q >= g3ms_pkg::row_t'(2)) && !sel_cur_row;
    row_in[1] = r_ge1;
    row_in[2] = 1'b1;
    col_in[0] = (c_q >= g3ms_pkg::col_t'(2)) && !sel_cur_col;
    col_in[1] = c_ge1;
    col_in[2] = 1'b1;
    sum_d = '0;
    cnt_d = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_in[i] && col_in[j]) begin
          sum_d = sum_d + g3ms_pkg::sum_t'(v[i][j]);
          cnt_d = cnt_d + g3ms_pkg::cnt_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
      res_row_q  <= sel_cur_row ? r_q : r_q - g3ms_pkg::row_t'(1);
      res_col_q  <= sel_cur_col ? c_q : c_q - g3ms_pkg::col_t'(1);
      res_last_q <= cmd_i.last;
      res_done_q <= (cmd_i.sel == g3ms_pkg::ResHere);
    end
  end

  // Truncated divide by the count: multiply by the ceiling reciprocal
  g3ms_pkg::prod_t   prod;
  g3ms_pkg::sample_t quo_q;

  assign prod = g3ms_pkg::prod_t'(sum_q) * g3ms_pkg::prod_t'(g3ms_pkg::recip(cnt_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      quo_q <= prod[g3ms_pkg::RecipShift +: g3ms_pkg::SampleW];
    end
  end

  // Output register
  logic out_valid_q;
  g3ms_pkg::sample_t out_height_q;
  g3ms_pkg::row_t out_row_q;
  g3ms_pkg::col_t out_col_q;
  logic out_last_q, out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_height_q <= quo_q;
      out_row_q    <= res_row_q;
      out_col_q    <= res_col_q;
      out_last_q   <= res_last_q;
      out_done_q   <= res_done_q;
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign out_height_o = out_height_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign out_last_o   = out_last_q;
  assign out_done_o   = out_done_q;

endmodule

[rtl/grid_3x3_mean_smoother.sv]
// Top level of the 3x3 mean smoother: sequencer plus datapath.
// Depends on g3ms_pkg, g3ms_if, g3ms_ctrl and g3ms_dpath.

// Streaming 3x3 box filter over a height grid sent in raster order. Each word
// out is the truncated mean of the in-grid neighbours of one point, with its
// row and column; points come out in raster order once their neighbourhood is
// complete, so a row end and the last row give extra words. last_of_run marks
// the final word caused by an input sample, frame_done the grid's final word.
// One sample is in work at a time: captured as the line stores are read, then
// loaded as they are written back. Each point it completes (up to 4) then goes
// in turn through the shared sum, reciprocal multiply and push steps; a push
// waits while the output register holds an untaken word, and that register
// lets the next sample enter while the last word waits to be taken. A config
// write (grid_width index 0, grid_height index 1) restarts the grid at row 0,
// column 0; write only while the block is idle. No clearing pass after reset.
module grid_3x3_mean_smoother (
  input logic            clk_i,
  input logic            rst_ni,
  g3ms_sample_if.sink    sample_i,
  g3ms_result_if.source  result_o,
  g3ms_cfg_if.sink       cfg_i
);

  g3ms_pkg::ctrl_cmd_t  cmd;
  g3ms_pkg::dp_status_t status;
  logic                 in_ready;

  g3ms_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(sample_i.valid),
    .in_ready_o(in_ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  g3ms_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (sample_i.height_sample),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_height_o(result_o.smoothed_height),
    .out_row_o   (result_o.out_row),
    .out_col_o   (result_o.out_col),
    .out_last_o  (result_o.last_of_run),
    .out_done_o  (result_o.frame_done)
  );

  assign sample_i.ready = in_ready;
  // config registers take a write in any cycle
  assign cfg_i.ready    = 1'b1;

endmodule

[rtl/g3ms_checker.sv]
// Port-level assertions for the 3x3 mean smoother, bound to the top level.
// Depends on g3ms_pkg; tracks grid_width from the config port.
module g3ms_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input g3ms_pkg::sample_t    smoothed_height_i,
  input g3ms_pkg::row_t       out_row_i,
  input g3ms_pkg::col_t       out_col_i,
  input logic                 last_of_run_i,
  input logic                 frame_done_i,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_i,
  input g3ms_pkg::cfg_idx_t   cfg_index_i,
  input g3ms_pkg::cfg_data_t  cfg_data_i
);

  g3ms_pkg::cfg_width_t width_q, eff_w;

  // shadow of the width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= g3ms_pkg::CfgWidthRst;
    end else if (cfg_valid_i && cfg_ready_i && cfg_index_i == g3ms_pkg::CfgIdxWidth) begin
      width_q <= cfg_data_i[g3ms_pkg::CfgWidthW-1:0];
    end
  end

  always_comb begin
    priority if (width_q == '0) begin
      eff_w = g3ms_pkg::cfg_width_t'(1);
    end else if (width_q > g3ms_pkg::cfg_width_t'(g3ms_pkg::MaxWidth)) begin
      eff_w = g3ms_pkg::cfg_width_t'(g3ms_pkg::MaxWidth);
    end else begin
      eff_w = width_q;
    end
  end

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({smoothed_height_i, out_row_i, out_col_i, last_of_run_i, frame_done_i}))
    else $error("result word changed while stalled");

  // the grid's final word also closes its run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> last_of_run_i)
    else $error("frame_done without last_of_run");

  // columns stay inside the configured row
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> g3ms_pkg::cfg_width_t'(out_col_i) < eff_w)
    else $error("out_col beyond grid width");

  // the grid's final point sits in the last column
  a_done_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |->
      g3ms_pkg::cfg_width_t'(out_col_i) == eff_w - g3ms_pkg::cfg_width_t'(1))
    else $error("frame_done away from the last column");

endmodule

bind grid_3x3_mean_smoother g3ms_checker u_g3ms_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .smoothed_height_i(result_o.smoothed_height),
  .out_row_i        (result_o.out_row),
  .out_col_i        (result_o.out_col),
  .last_of_run_i    (result_o.last_of_run),
  .frame_done_i     (result_o.frame_done),
  .cfg_valid_i      (cfg_i.valid),
  .cfg_ready_i      (cfg_i.ready),
  .cfg_index_i      (cfg_i.index),
  .cfg_data_i       (cfg_i.data)
);
